### sv/slb_pkg.sv
// ----------------------------------------------------------------------------
// slb_pkg: shared definitions for the suffix array and LCP builder
// Sizes, request and status codes, and the request and result records.
// ----------------------------------------------------------------------------
package slb_pkg;

  localparam int MAX_TEXT = 1023;
  localparam int ADDR_W   = 10;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int IDX_W    = ADDR_W + 1;
  localparam int KEY_W    = 9;
  localparam int SYM_KEYS = 257;

  // Request kinds.
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        symbol;
    logic [ADDR_W-1:0] rank_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] stored_length;
    logic [ADDR_W-1:0] lcp_length;
    logic [ADDR_W-1:0] suffix_start;
  } res_t;

endpackage

### sv/slb_ram.sv
// ----------------------------------------------------------------------------
// slb_ram: single write port, single read port memory
// The read data is registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module slb_ram #(
  parameter int WIDTH = 10
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [slb_pkg::ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic [slb_pkg::ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]          rdata
);
  import slb_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/slb_alu.sv
// ----------------------------------------------------------------------------
// slb_alu: shared modular adder
// Adds two positions below n, the text length plus one, and wraps the sum once.
// ----------------------------------------------------------------------------
module slb_alu (
  input  logic [slb_pkg::IDX_W-1:0]  a,
  input  logic [slb_pkg::IDX_W-1:0]  b,
  input  logic [slb_pkg::IDX_W-1:0]  n,
  output logic [slb_pkg::ADDR_W-1:0] y
);
  import slb_pkg::*;

  logic [IDX_W:0] sum;
  logic [IDX_W:0] wrapped;

  // Both operands stay below n, so one subtract brings the sum back in range.
  always_comb begin
    sum     = {1'b0, a} + {1'b0, b};
    wrapped = (sum >= {1'b0, n}) ? sum - {1'b0, n} : sum;
    y       = wrapped[ADDR_W-1:0];
  end

endmodule

### sv/slb_core.sv
// ----------------------------------------------------------------------------
// slb_core: sequencer and working memories
// Loads text, sorts rotations by prefix doubling with counting sorts, runs the
// Kasai LCP walk, and serves rank reads, one memory access step at a time.
// ----------------------------------------------------------------------------
module slb_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  slb_pkg::req_t  req,
  output logic           idle,
  input  logic           out_free,
  output logic           res_valid,
  output slb_pkg::res_t  res
);
  import slb_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RDW  = 5'd1;
  localparam logic [4:0] S_DONE = 5'd2;
  localparam logic [4:0] S_CLR  = 5'd3;
  localparam logic [4:0] S_KA   = 5'd4;
  localparam logic [4:0] S_KB   = 5'd5;
  localparam logic [4:0] S_KC   = 5'd6;
  localparam logic [4:0] S_CA   = 5'd7;
  localparam logic [4:0] S_CB   = 5'd8;
  localparam logic [4:0] S_PF0  = 5'd9;
  localparam logic [4:0] S_PF1  = 5'd10;
  localparam logic [4:0] S_C0   = 5'd11;
  localparam logic [4:0] S_C1   = 5'd12;
  localparam logic [4:0] S_C2   = 5'd13;
  localparam logic [4:0] S_DBL  = 5'd14;
  localparam logic [4:0] S_T0   = 5'd15;
  localparam logic [4:0] S_T1   = 5'd16;
  localparam logic [4:0] S_N0   = 5'd17;
  localparam logic [4:0] S_N1   = 5'd18;
  localparam logic [4:0] S_N2   = 5'd19;
  localparam logic [4:0] S_N3   = 5'd20;
  localparam logic [4:0] S_P0   = 5'd21;
  localparam logic [4:0] S_P1   = 5'd22;
  localparam logic [4:0] S_KS   = 5'd23;
  localparam logic [4:0] S_Q0   = 5'd24;
  localparam logic [4:0] S_Q1   = 5'd25;
  localparam logic [4:0] S_Q2   = 5'd26;
  localparam logic [4:0] S_W0   = 5'd27;
  localparam logic [4:0] S_W1   = 5'd28;
  localparam logic [4:0] S_W2   = 5'd29;
  localparam logic [4:0] S_WE   = 5'd30;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

  logic [4:0]        state;
  logic [ADDR_W-1:0] text_len;
  logic              built;
  logic [IDX_W-1:0]  n;
  logic [IDX_W-1:0]  i;
  logic [IDX_W-1:0]  mask;
  logic              init_pass;
  logic              scatter;
  logic [ADDR_W-1:0] p;
  logic [ADDR_W-1:0] key;
  logic [IDX_W:0]    kpos;
  logic [IDX_W:0]    run;
  logic [KEY_W-1:0]  prev_key;
  logic [ADDR_W-1:0] prev_cls;
  logic [ADDR_W-1:0] a_pos;
  logic [ADDR_W-1:0] q_pos;
  logic [ADDR_W-1:0] ra;
  logic [ADDR_W-1:0] prev_ra;
  logic [ADDR_W-1:0] prev_rq;
  logic [ADDR_W-1:0] r;
  logic [ADDR_W-1:0] prev_start;
  logic [ADDR_W-1:0] m;
  logic [KEY_W-1:0]  ka;
  logic [ADDR_W-1:0] rank;
  logic [ADDR_W-1:0] res_start;
  logic [ADDR_W-1:0] res_lcp;
  logic [1:0]        res_status;

  // Memory ports.
  logic              txt_we, sa_we, rk_we, tmp_we, cnt_we, pre_we;
  logic [ADDR_W-1:0] txt_wa, sa_wa, rk_wa, tmp_wa, cnt_wa, pre_wa;
  logic [ADDR_W-1:0] txt_ra, sa_ra, rk_ra, tmp_ra, cnt_ra, pre_ra;
  logic [7:0]        txt_wd, txt_rd;
  logic [ADDR_W-1:0] sa_wd, sa_rd, rk_wd, rk_rd, tmp_wd, tmp_rd, pre_wd, pre_rd;
  logic [IDX_W-1:0]  cnt_wd, cnt_rd;

  logic [IDX_W-1:0]  alu_a, alu_b;
  logic [ADDR_W-1:0] alu_y;
  logic [KEY_W-1:0]  keyf;
  logic              last_i;
  logic [IDX_W:0]    pos_im;
  logic [IDX_W:0]    pos_pm;
  logic [IDX_W-1:0]  pf_limit;

  slb_ram #(.WIDTH(8)) u_text (
    .clk(clk), .we(txt_we), .waddr(txt_wa), .wdata(txt_wd), .raddr(txt_ra), .rdata(txt_rd)
  );
  slb_ram #(.WIDTH(ADDR_W)) u_order (
    .clk(clk), .we(sa_we), .waddr(sa_wa), .wdata(sa_wd), .raddr(sa_ra), .rdata(sa_rd)
  );
  slb_ram #(.WIDTH(ADDR_W)) u_class (
    .clk(clk), .we(rk_we), .waddr(rk_wa), .wdata(rk_wd), .raddr(rk_ra), .rdata(rk_rd)
  );
  slb_ram #(.WIDTH(ADDR_W)) u_scratch (
    .clk(clk), .we(tmp_we), .waddr(tmp_wa), .wdata(tmp_wd), .raddr(tmp_ra), .rdata(tmp_rd)
  );
  slb_ram #(.WIDTH(IDX_W)) u_bucket (
    .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd)
  );
  slb_ram #(.WIDTH(ADDR_W)) u_prefix (
    .clk(clk), .we(pre_we), .waddr(pre_wa), .wdata(pre_wd), .raddr(pre_ra), .rdata(pre_rd)
  );

  slb_alu u_alu (.a(alu_a), .b(alu_b), .n(n), .y(alu_y));

  // Symbol key of the position just read: sentinel 0, byte b as b + 1.
  always_comb begin
    keyf     = (kpos < {2'b0, text_len}) ? {1'b0, txt_rd} + KEY_W'(1) : '0;
    last_i   = (i + IDX_W'(1)) == n;
    pos_im   = {1'b0, i} + {2'b0, m};
    pos_pm   = {2'b0, prev_start} + {2'b0, m};
    pf_limit = init_pass ? IDX_W'(SYM_KEYS) : n;
    idle     = state == S_IDLE;
    res_valid = (state == S_DONE) && out_free;
  end

  // Result record; the stored length always follows the text length.
  always_comb begin
    res.suffix_start  = res_start;
    res.lcp_length    = res_lcp;
    res.stored_length = text_len;
    res.status        = res_status;
  end

  // Shared adder operands.
  always_comb begin
    alu_a = {1'b0, sa_rd};
    alu_b = (state == S_T1) ? n - mask : mask;
  end

  // Memory address and write control by step.
  always_comb begin
    txt_we = 1'b0; txt_wa = text_len; txt_wd = req.symbol; txt_ra = i[ADDR_W-1:0];
    sa_we  = 1'b0; sa_wa  = cnt_rd[ADDR_W-1:0]; sa_wd = p; sa_ra = i[ADDR_W-1:0];
    rk_we  = 1'b0; rk_wa  = a_pos; rk_wd = '0; rk_ra = i[ADDR_W-1:0];
    tmp_we = 1'b0; tmp_wa = i[ADDR_W-1:0]; tmp_wd = alu_y; tmp_ra = i[ADDR_W-1:0];
    cnt_we = 1'b0; cnt_wa = i[ADDR_W-1:0]; cnt_wd = '0; cnt_ra = i[ADDR_W-1:0];
    pre_we = 1'b0; pre_wa = a_pos; pre_wd = '0; pre_ra = i[ADDR_W-1:0];
    unique case (state)
      S_IDLE: begin
        sa_ra  = req.rank_index;
        pre_ra = req.rank_index;
        if (req_valid && req.mode == MODE_LOAD) begin
          txt_wa = built ? '0 : text_len;
          txt_we = built || (32'(text_len) < MAX_TEXT);
        end
      end
      S_CLR: cnt_we = 1'b1;
      S_KB:  rk_ra = tmp_rd;
      S_CA:  cnt_ra = key;
      S_CB: begin
        cnt_we = 1'b1;
        cnt_wa = key;
        cnt_wd = cnt_rd + IDX_W'(1);
        sa_we  = scatter;
      end
      S_PF1: begin
        cnt_we = 1'b1;
        cnt_wd = run[IDX_W-1:0];
      end
      S_C1: txt_ra = sa_rd;
      S_C2: begin
        rk_we = 1'b1;
        rk_wd = (i == '0) ? '0 : prev_cls + ADDR_W'(keyf != prev_key);
      end
      S_T1: tmp_we = 1'b1;
      S_N1: rk_ra = sa_rd;
      S_N2: rk_ra = q_pos;
      S_N3: begin
        pre_we = 1'b1;
        pre_wd = (i == '0) ? '0 :
                 prev_cls + ADDR_W'(!(ra == prev_ra && rk_rd == prev_rq));
      end
      S_P1: begin
        rk_we = 1'b1;
        rk_wa = i[ADDR_W-1:0];
        rk_wd = pre_rd;
      end
      S_Q1: sa_ra = rk_rd - ADDR_W'(1);
      S_W0: txt_ra = pos_im[ADDR_W-1:0];
      S_W1: txt_ra = pos_pm[ADDR_W-1:0];
      S_WE: begin
        pre_we = 1'b1;
        pre_wa = r;
        pre_wd = m;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      text_len <= '0;
      built    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          res_start  <= '0;
          res_lcp    <= '0;
          res_status <= ST_OK;
          rank       <= req.rank_index;
          if (req_valid) begin
            state <= S_DONE;
            case (req.mode)
              MODE_LOAD: begin
                if (built) begin
                  built    <= 1'b0;
                  text_len <= ADDR_W'(1);
                end else if (32'(text_len) < MAX_TEXT) begin
                  text_len <= text_len + ADDR_W'(1);
                end else begin
                  res_status <= ST_FULL;
                end
              end
              MODE_BUILD: begin
                n         <= {1'b0, text_len} + IDX_W'(1);
                i         <= '0;
                init_pass <= 1'b1;
                state     <= S_CLR;
              end
              MODE_READ: begin
                if (!built) begin
                  res_status <= ST_NOT_BUILT;
                end else if (req.rank_index > text_len) begin
                  res_status <= ST_RANGE;
                end else begin
                  state <= S_RDW;
                end
              end
              default: ;
            endcase
          end
        end
        S_RDW: begin
          res_start <= sa_rd;
          res_lcp   <= (rank == '0) ? '0 : pre_rd;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        // Clear every bucket counter.
        S_CLR: begin
          i <= i + IDX_W'(1);
          if (i == LAST_SLOT) begin
            i       <= '0;
            scatter <= 1'b0;
            state   <= S_KA;
          end
        end
        // Fetch the sort key of element i.
        S_KA: begin
          kpos  <= {1'b0, i};
          state <= S_KB;
        end
        S_KB: begin
          if (init_pass) begin
            p     <= i[ADDR_W-1:0];
            key   <= {1'b0, keyf};
            state <= S_CA;
          end else begin
            p     <= tmp_rd;
            state <= S_KC;
          end
        end
        S_KC: begin
          key   <= rk_rd;
          state <= S_CA;
        end
        S_CA: state <= S_CB;
        // Count, or place the element and advance its bucket.
        S_CB: begin
          i     <= i + IDX_W'(1);
          state <= S_KA;
          if (last_i) begin
            i <= '0;
            if (!scatter) begin
              run   <= '0;
              state <= S_PF0;
            end else begin
              state <= init_pass ? S_C0 : S_N0;
            end
          end
        end
        // Exclusive prefix sum over the buckets.
        S_PF0: state <= S_PF1;
        S_PF1: begin
          run   <= run + {1'b0, cnt_rd};
          i     <= i + IDX_W'(1);
          state <= S_PF0;
          if ((i + IDX_W'(1)) == pf_limit) begin
            i       <= '0;
            scatter <= 1'b1;
            state   <= S_KA;
          end
        end
        // First classes from single symbols.
        S_C0: state <= S_C1;
        S_C1: begin
          kpos  <= {2'b0, sa_rd};
          a_pos <= sa_rd;
          state <= S_C2;
        end
        S_C2: begin
          prev_key <= keyf;
          prev_cls <= rk_wd;
          i        <= i + IDX_W'(1);
          state    <= S_C0;
          if (last_i) begin
            mask  <= IDX_W'(1);
            state <= S_DBL;
          end
        end
        S_DBL: begin
          i     <= '0;
          state <= (mask >= n) ? S_KS : S_T0;
        end
        // Shift each start back by the current span.
        S_T0: state <= S_T1;
        S_T1: begin
          i     <= i + IDX_W'(1);
          state <= S_T0;
          if (last_i) begin
            i         <= '0;
            init_pass <= 1'b0;
            state     <= S_CLR;
          end
        end
        // New classes from pairs of old classes.
        S_N0: state <= S_N1;
        S_N1: begin
          a_pos <= sa_rd;
          q_pos <= alu_y;
          state <= S_N2;
        end
        S_N2: begin
          ra    <= rk_rd;
          state <= S_N3;
        end
        S_N3: begin
          prev_ra  <= ra;
          prev_rq  <= rk_rd;
          prev_cls <= pre_wd;
          i        <= i + IDX_W'(1);
          state    <= S_N0;
          if (last_i) begin
            i     <= '0;
            state <= S_P0;
          end
        end
        // Copy the new classes back.
        S_P0: state <= S_P1;
        S_P1: begin
          i     <= i + IDX_W'(1);
          state <= S_P0;
          if (last_i) begin
            mask  <= mask << 1;
            state <= S_DBL;
          end
        end
        // Kasai walk over text positions.
        S_KS: begin
          m <= '0;
          if (n == IDX_W'(1)) begin
            built <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_Q0;
          end
        end
        S_Q0: state <= S_Q1;
        S_Q1: begin
          r <= rk_rd;
          if (rk_rd == '0) begin
            m     <= '0;
            i     <= i + IDX_W'(1);
            state <= S_Q0;
            if ((i + IDX_W'(2)) == n) begin
              built <= 1'b1;
              state <= S_DONE;
            end
          end else begin
            state <= S_Q2;
          end
        end
        S_Q2: begin
          prev_start <= sa_rd;
          state      <= S_W0;
        end
        S_W0: begin
          kpos <= pos_im;
          if (pos_im < {1'b0, n} && pos_pm < {1'b0, n}) begin
            state <= S_W1;
          end else begin
            state <= S_WE;
          end
        end
        S_W1: begin
          ka    <= keyf;
          kpos  <= pos_pm;
          state <= S_W2;
        end
        S_W2: begin
          if (keyf == ka) begin
            m     <= m + ADDR_W'(1);
            state <= S_W0;
          end else begin
            state <= S_WE;
          end
        end
        S_WE: begin
          if (m != '0) begin
            m <= m - ADDR_W'(1);
          end
          i     <= i + IDX_W'(1);
          state <= S_Q0;
          if ((i + IDX_W'(2)) == n) begin
            built <= 1'b1;
            state <= S_DONE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/suffix_array_lcp_builder.sv
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder: suffix array and LCP array builder
//
//   channel  | direction | contents
//   s_axis   | in        | tuser: mode; tdata: symbol, rank_index
//   m_axis   | out       | tdata: suffix_start, lcp_length, stored_length, status
//
// A build makes one memory access per cycle: a counting sort by symbol, then a
// doubling pass per span (each clears all 1024 buckets), then the Kasai walk.
// The input is not ready until the result moves to the output register. Reset
// clears the length and the built flag; memories keep contents.
// ----------------------------------------------------------------------------
module suffix_array_lcp_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // symbol[7:0], rank_index[17:8], zero pad
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // suffix_start, lcp_length, stored_length, status
);
  import slb_pkg::*;

  req_t req;
  res_t res;
  logic idle;
  logic out_free;
  logic res_valid;

  always_comb begin
    req.mode       = s_tuser;
    req.symbol     = s_tdata[7:0];
    req.rank_index = s_tdata[17:8];
    s_tready       = idle;
    out_free       = !m_tvalid || m_tready;
  end

  slb_core u_core (
    .clk(clk), .rst(rst), .req_valid(s_tvalid && idle), .req(req), .idle(idle),
    .out_free(out_free), .res_valid(res_valid), .res(res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {res.status, res.stored_length, res.lcp_length, res.suffix_start};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

### tb/suffix_array_lcp_builder_tb.sv
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder_tb: self-checking bench for the suffix array builder
// Loads random texts, builds suffix and LCP arrays, and reads ranks back. A
// scoreboard predicts each result from its own copy of the text, computes the
// arrays by plain rotation comparison, and checks results in request order.
// ----------------------------------------------------------------------------
module suffix_array_lcp_builder_tb;
  import slb_pkg::*;

  // Scoreboard: mirrors the text, predicts and checks results.
  class lcp_scoreboard;
    logic [7:0]        text_bytes[MAX_TEXT];
    int                text_len;
    bit                is_built;
    int                order[DEPTH];
    int                lcp_at[DEPTH];
    res_t              pending[$];
    int                mismatches;

    function new();
      text_len   = 0;
      is_built   = 0;
      mismatches = 0;
    endfunction

    // Symbol key: sentinel is 0, byte b is b + 1.
    function int key_at(int pos);
      return (pos < text_len) ? int'(text_bytes[pos]) + 1 : 0;
    endfunction

    // Compare rotations starting at a and b; the sentinel makes them distinct.
    function int rot_less(int a, int b, int n);
      int k;
      for (k = 0; k < n; k++) begin
        if (key_at((a + k) % n) != key_at((b + k) % n))
          return key_at((a + k) % n) < key_at((b + k) % n);
      end
      return a < b;
    endfunction

    function void build_arrays();
      int n, i, j, t, m;
      n = text_len + 1;
      for (i = 0; i < n; i++) order[i] = i;
      // Insertion sort of rotations.
      for (i = 1; i < n; i++) begin
        t = order[i];
        j = i - 1;
        while (j >= 0 && rot_less(t, order[j], n)) begin
          order[j + 1] = order[j];
          j--;
        end
        order[j + 1] = t;
      end
      lcp_at[0] = 0;
      for (i = 1; i < n; i++) begin
        m = 0;
        while (order[i] + m < n && order[i - 1] + m < n &&
               key_at(order[i] + m) == key_at(order[i - 1] + m)) m++;
        lcp_at[i] = m;
      end
      is_built = 1;
    endfunction

    // Note an accepted request and queue its expected result.
    function void note_request(logic [1:0] mode, logic [7:0] sym, logic [9:0] rank);
      res_t r;
      r = '0;
      r.status = ST_OK;
      if (mode == MODE_LOAD) begin
        if (is_built) begin
          is_built = 0;
          text_len = 0;
        end
        if (text_len >= MAX_TEXT) r.status = ST_FULL;
        else begin
          text_bytes[text_len] = sym;
          text_len++;
        end
      end else if (mode == MODE_BUILD) begin
        build_arrays();
      end else if (mode == MODE_READ) begin
        if (!is_built) r.status = ST_NOT_BUILT;
        else if (int'(rank) > text_len) r.status = ST_RANGE;
        else begin
          r.suffix_start = ADDR_W'(order[rank]);
          r.lcp_length   = ADDR_W'(lcp_at[rank]);
        end
      end
      r.stored_length = ADDR_W'(text_len);
      pending.push_back(r);
    endfunction

    // Check one accepted result against the oldest expectation.
    function void check_result(logic [31:0] data);
      res_t got, exp_r;
      got = res_t'(data);
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", data);
        return;
      end
      exp_r = pending.pop_front();
      if (got.suffix_start !== exp_r.suffix_start || got.lcp_length !== exp_r.lcp_length ||
          got.stored_length !== exp_r.stored_length || got.status !== exp_r.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: start %0d/%0d lcp %0d/%0d len %0d/%0d status %0d/%0d",
                   exp_r.suffix_start, got.suffix_start, exp_r.lcp_length,
                   got.lcp_length, exp_r.stored_length, got.stored_length,
                   exp_r.status, got.status);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;

  lcp_scoreboard board = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;
  int  quiet_cycles = 0;
  int  quiet_limit = 1000000;

  suffix_array_lcp_builder DUT (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  // Note requests and check results at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_request(s_tuser, s_tdata[7:0], s_tdata[17:8]);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= quiet_limit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver readiness, with random stalls and a long hold-off.
  always @(negedge clk) begin
    if (hold_off) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one request, idling at random beforehand.
  task automatic send_request(logic [1:0] mode, logic [7:0] sym, logic [9:0] rank);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= mode;
    s_tdata  <= {6'd0, rank, sym};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Load a short random text, build it, and read ranks, some out of range.
  task automatic text_session(int len);
    int i;
    for (i = 0; i < len; i++)
      send_request(MODE_LOAD, ($urandom_range(3) == 0) ? 8'($urandom) :
                   8'($urandom_range(97, 99)), 10'($urandom));
    send_request(MODE_BUILD, 8'($urandom), 10'($urandom));
    for (i = 0; i < len + 3; i++)
      send_request(MODE_READ, 8'($urandom),
                   ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(len + 1)));
  endtask

  task automatic random_phase(int sessions);
    int k;
    for (k = 0; k < sessions; k++) begin
      if ($urandom_range(9) == 0)
        send_request(2'($urandom), 8'($urandom), 10'($urandom));
      text_session($urandom_range(1, 6));
    end
  endtask

  initial begin
    int i;
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: read before build, empty build, repeated build, unused mode.
    send_request(MODE_READ, 8'h00, 10'd0);
    send_request(MODE_BUILD, 8'h00, 10'd0);
    send_request(MODE_READ, 8'h00, 10'd0);
    send_request(MODE_READ, 8'hff, 10'd1);
    send_request(2'd3, 8'hff, 10'h3ff);
    send_request(MODE_LOAD, 8'hff, 10'h3ff);
    send_request(MODE_LOAD, 8'h00, 10'd0);
    send_request(MODE_LOAD, 8'hff, 10'd0);
    send_request(MODE_BUILD, 8'h00, 10'd0);
    send_request(MODE_BUILD, 8'h00, 10'd0);
    for (i = 0; i < 4; i++) send_request(MODE_READ, 8'h00, 10'(i));
    send_request(MODE_READ, 8'h00, 10'h3ff);
    drain();

    // Phases of idling and stalling.
    random_phase(8);
    send_idle_pct = 75; random_phase(8);
    send_idle_pct = 0; recv_stall_pct = 75; random_phase(8);
    send_idle_pct = 20; recv_stall_pct = 20; random_phase(8);

    // Long receiver hold-off while loads keep coming.
    send_idle_pct = 0; recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      for (i = 0; i < 30; i++) send_request(MODE_LOAD, 8'($urandom), 10'd0);
    join
    send_request(MODE_BUILD, 8'h00, 10'd0);
    send_request(MODE_READ, 8'h00, 10'd30);
    drain();

    // Fill to capacity once, then overflow; the next session builds the full text.
    for (i = 0; i < MAX_TEXT + 2; i++) send_request(MODE_LOAD, 8'($urandom), 10'd0);
    drain();
    random_phase(3);
    drain();

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
